@@ design/rsde_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the reduced spectral density evaluator.
package rsde_pkg;

  // Configuration register indexes (terms occupy 0 .. TERM_COUNT-1)
  localparam logic [2:0] REG_TERM0      = 3'd0;
  localparam logic [2:0] REG_HERTZ_MODE = 3'd5;
  localparam logic [2:0] REG_FREQ_SHIFT = 3'd6;

  // Two pi in Q.32, split into a high and a low word
  localparam logic [2:0]  TWO_PI_HI = 3'd6;
  localparam logic [31:0] TWO_PI_LO = 32'd1216271633;

  // Quotient bits of the Lorentzian divide (divisor is at least 2^16)
  localparam int DIV_STEPS = 47;

  // Reciprocal of five, ceil(2^41 / 5), split into words
  localparam int          RECIP_SHIFT = 41;
  localparam logic [6:0]  RECIP5_HI   = 7'd102;
  localparam logic [31:0] RECIP5_LO   = 32'd1717986919;

  // Half of 5 * 2^16 for round to nearest
  localparam logic [54:0] ROUND_HALF = 55'd163840;

  localparam logic [47:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OUT_NEG_MAG = 48'h8000_0000_0000;

endpackage

@@ design/reduced_spectral_density_eval.sv @@
`timescale 1ns / 1ps
// Top level: five-term Lorentzian spectral density evaluator, fully pipelined.
//
// A request is taken on every clock edge with start high (busy never rises), so one
// pair of energies can enter in each cycle. Each request yields exactly one result,
// shown on the out_ ports for one cycle with out_valid high; the receiver cannot
// stall and results come out in request order. Each term forms tau / (1 + x^2)
// in a 47-stage restoring divider; the terms run in parallel lanes. Write the
// configuration registers only while no request is in flight.
module reduced_spectral_density_eval #(
  parameter int TERM_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_energy_row,
  input  logic [31:0] in_energy_col,
  output logic        out_valid,
  output logic [47:0] out_j_value,
  output logic [47:0] out_q_value,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam int DS      = rsde_pkg::DIV_STEPS;
  localparam int LAT     = 18 + DS;   // total latency in cycles
  localparam int WNEG_LN = 12 + DS;   // sign of w from stage 2 to stage 60

  // ---------------------------------------------------------------- config
  logic [62:0] term_r [TERM_COUNT];
  logic        hertz_r;
  logic [31:0] shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TERM_COUNT; k++) term_r[k] <= '0;
      hertz_r <= 1'b0;
      shift_r <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < TERM_COUNT; k++) begin
        if (cfg_index == rsde_pkg::REG_TERM0 + 3'(k)) term_r[k] <= cfg_data;
      end
      if (cfg_index == rsde_pkg::REG_HERTZ_MODE) hertz_r <= cfg_data[0];
      if (cfg_index == rsde_pkg::REG_FREQ_SHIFT) shift_r <= cfg_data[31:0];
    end
  end

  // Never stall: every stage advances on every clock.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits travel alongside the free-running data stages.
  logic [LAT-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[LAT-2:0], accept};
  end

  // ---------------------------------------------------------------- frequency
  logic [33:0] w1_r;
  logic [33:0] wabs;
  logic [32:0] wmag2_r, wmag3_r;
  logic [64:0] pl3_r;
  logic [35:0] ph3_r;
  logic [68:0] hz_sum;
  logic [59:0] om4_r;
  logic [WNEG_LN-1:0] wneg_d_r;

  assign wabs   = w1_r[33] ? (~w1_r + 34'd1) : w1_r;
  assign hz_sum = {1'b0, ph3_r, 32'b0} + 69'(pl3_r);

  always_ff @(posedge clk) begin
    // Stage 1: transition frequency
    w1_r <= {{2{in_energy_row[31]}}, in_energy_row}
          - {{2{in_energy_col[31]}}, in_energy_col}
          + {{2{shift_r[31]}}, shift_r};
    // Stage 2: magnitude, keep the sign aside
    wmag2_r  <= wabs[32:0];
    wneg_d_r <= {wneg_d_r[WNEG_LN-2:0], w1_r[33]};
    // Stage 3: two pi partial products
    pl3_r   <= 65'(wmag2_r) * 65'(rsde_pkg::TWO_PI_LO);
    ph3_r   <= 36'(wmag2_r) * 36'(rsde_pkg::TWO_PI_HI);
    wmag3_r <= wmag2_r;
    // Stage 4: angular frequency with 24 fraction bits
    om4_r <= hertz_r ? hz_sum[67:8] : {3'b0, wmag3_r, 24'b0};
  end

  // ---------------------------------------------------------------- lanes
  logic [49:0] wj_l [TERM_COUNT];
  logic [49:0] wq_l [TERM_COUNT];
  logic        cneg_l [TERM_COUNT];

  for (genvar k = 0; k < TERM_COUNT; k++) begin : g_lane
    logic [30:0] tau;
    logic [31:0] craw, cmag;
    logic        cneg;

    assign tau  = term_r[k][62:32];
    assign craw = term_r[k][31:0];
    assign cneg = craw[31];
    assign cmag = cneg ? (~craw + 32'd1) : craw;
    assign cneg_l[k] = cneg;

    logic [60:0]  ta5_r, tb5_r;
    logic [90:0]  xs;
    logic [58:0]  x6_r, x7_r, x8_r, x9_r;
    logic [59:0]  pll7_r;
    logic [58:0]  plh7_r;
    logic [57:0]  phh7_r;
    logic [117:0] sq8_r;
    logic [63:0]  x2;
    logic [64:0]  den_sum;
    logic [63:0]  den9_r;

    assign xs      = 91'(ta5_r) + {tb5_r, 30'b0};
    assign x2      = (|sq8_r[117:112]) ? '1 : sq8_r[111:48];
    assign den_sum = {1'b0, x2} + 65'h1_0000;

    always_ff @(posedge clk) begin
      // x = tau * om >> 32
      ta5_r  <= 61'(tau) * 61'(om4_r[29:0]);
      tb5_r  <= 61'(tau) * 61'(om4_r[59:30]);
      x6_r   <= xs[90:32];
      // x squared in three partial products
      pll7_r <= 60'(x6_r[29:0]) * 60'(x6_r[29:0]);
      plh7_r <= 59'(x6_r[29:0]) * 59'(x6_r[58:30]);
      phh7_r <= 58'(x6_r[58:30]) * 58'(x6_r[58:30]);
      x7_r   <= x6_r;
      sq8_r  <= 118'(pll7_r) + 118'({plh7_r, 31'b0}) + {phh7_r, 60'b0};
      x8_r   <= x7_r;
      // 1 + x^2 in Q.16, clamped to the full word
      den9_r <= den_sum[64] ? '1 : den_sum[63:0];
      x9_r   <= x8_r;
    end

    // Restoring divider: (tau << 32) / den, one quotient bit per stage
    logic [63:0]    rem_r [DS];
    logic [63:0]    dd_r  [DS];
    logic [DS-1:0]  q_r   [DS];
    logic [58:0]    xd_r  [DS];

    for (genvar d = 0; d < DS; d++) begin : g_div
      localparam int BIT = DS - 1 - d;
      logic [63:0]   r_in, den_in;
      logic [DS-1:0] q_in;
      logic [58:0]   x_in;
      logic          nb, ge;
      logic [64:0]   rs, df;

      if (d == 0) begin : g_first
        // numerator bits above the quotient range seed the remainder
        assign r_in   = {48'b0, tau[30:15]};
        assign den_in = den9_r;
        assign q_in   = '0;
        assign x_in   = x9_r;
      end else begin : g_next
        assign r_in   = rem_r[d-1];
        assign den_in = dd_r[d-1];
        assign q_in   = q_r[d-1];
        assign x_in   = xd_r[d-1];
      end

      if (BIT >= 32) begin : g_tbit
        assign nb = tau[BIT-32];
      end else begin : g_zbit
        assign nb = 1'b0;
      end

      assign rs = {r_in, nb};
      assign df = rs - {1'b0, den_in};
      assign ge = rs >= {1'b0, den_in};

      always_ff @(posedge clk) begin
        rem_r[d] <= ge ? df[63:0] : rs[63:0];
        q_r[d]   <= {q_in[DS-2:0], ge};
        dd_r[d]  <= den_in;
        xd_r[d]  <= x_in;
      end
    end

    logic [DS-1:0] lt;
    logic [58:0]   xl;
    assign lt = q_r[DS-1];
    assign xl = xd_r[DS-1];

    logic [53:0]  pq0_r;
    logic [52:0]  pq1_r, pq2_r;
    logic [51:0]  pq3_r;
    logic [55:0]  pj0_r, pw0_r;
    logic [54:0]  pj1_r, pw1_r;
    logic [105:0] qsum;
    logic [78:0]  jsum, wsum;
    logic [46:0]  qt58_r;
    logic [49:0]  wj58_r, wj59_r, wj60_r, wq60_r;

    assign qsum = 106'(pq0_r) + 106'({pq1_r, 24'b0}) + 106'({pq2_r, 30'b0})
                + {pq3_r, 54'b0};
    assign jsum = 79'(pj0_r) + {pj1_r, 24'b0};
    assign wsum = 79'(pw0_r) + {pw1_r, 24'b0};

    always_ff @(posedge clk) begin
      // x * L and weighted L partial products
      pq0_r  <= 54'(xl[29:0]) * 54'(lt[23:0]);
      pq1_r  <= 53'(xl[29:0]) * 53'(lt[46:24]);
      pq2_r  <= 53'(xl[58:30]) * 53'(lt[23:0]);
      pq3_r  <= 52'(xl[58:30]) * 52'(lt[46:24]);
      pj0_r  <= 56'(lt[23:0]) * 56'(cmag);
      pj1_r  <= 55'(lt[46:24]) * 55'(cmag);
      // x * L stays below 2^79, so qt fits 47 bits
      qt58_r <= qsum[78:32];
      wj58_r <= jsum[77:28];
      // weight the dynamic shift term
      pw0_r  <= 56'(qt58_r[23:0]) * 56'(cmag);
      pw1_r  <= 55'(qt58_r[46:24]) * 55'(cmag);
      wj59_r <= wj58_r;
      wq60_r <= wsum[77:28];
      wj60_r <= wj59_r;
    end

    assign wj_l[k] = wj60_r;
    assign wq_l[k] = wq60_r;
  end

  // ---------------------------------------------------------------- sum and finish
  // Channel 0 carries J, channel 1 carries Q.
  logic [53:0] sum_nxt [2];
  logic [53:0] sum61_r [2];
  logic [53:0] mag62_r [2];
  logic        neg62_r [2], neg63_r [2], neg64_r [2];
  logic [54:0] rnd;
  logic [37:0] t63_r [2];
  logic [69:0] prl64_r [2];
  logic [44:0] prh64_r [2];
  logic [77:0] rsum [2];
  logic [36:0] quot [2];
  logic [47:0] mag48 [2];
  logic [47:0] res_nxt [2];
  logic        sat_nxt [2];
  logic        wneg60;

  assign wneg60 = wneg_d_r[WNEG_LN-1];
  assign rnd    = 55'(mag62_r[0]) + rsde_pkg::ROUND_HALF;

  always_comb begin
    sum_nxt[0] = '0;
    sum_nxt[1] = '0;
    for (int k = 0; k < TERM_COUNT; k++) begin
      // J takes the weight sign; Q is odd in w as well
      sum_nxt[0] = cneg_l[k] ? sum_nxt[0] - 54'(wj_l[k]) : sum_nxt[0] + 54'(wj_l[k]);
      sum_nxt[1] = (cneg_l[k] != wneg60) ? sum_nxt[1] - 54'(wq_l[k])
                                         : sum_nxt[1] + 54'(wq_l[k]);
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      rsum[c]  = 78'(prl64_r[c]) + 78'({prh64_r[c], 32'b0});
      quot[c]  = rsum[c][77:rsde_pkg::RECIP_SHIFT];
      mag48[c] = 48'(quot[c]);
      sat_nxt[c] = 1'b0;
      if (neg64_r[c]) begin
        if (mag48[c] > rsde_pkg::OUT_NEG_MAG) begin
          mag48[c]   = rsde_pkg::OUT_NEG_MAG;
          sat_nxt[c] = 1'b1;
        end
        res_nxt[c] = 48'd0 - mag48[c];
      end else begin
        if (mag48[c] > rsde_pkg::OUT_POS_MAX) begin
          mag48[c]   = rsde_pkg::OUT_POS_MAX;
          sat_nxt[c] = 1'b1;
        end
        res_nxt[c] = mag48[c];
      end
    end
  end

  logic [54:0] rnd_q;
  assign rnd_q = 55'(mag62_r[1]) + rsde_pkg::ROUND_HALF;

  logic [47:0] j_out_r, q_out_r;
  logic        ovf_out_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 2; c++) begin
      sum61_r[c] <= sum_nxt[c];
      // drop the sign, round on the magnitude
      neg62_r[c] <= sum61_r[c][53];
      mag62_r[c] <= sum61_r[c][53] ? (~sum61_r[c] + 54'd1) : sum61_r[c];
      neg63_r[c] <= neg62_r[c];
      neg64_r[c] <= neg63_r[c];
      // divide by five through the reciprocal
      prl64_r[c] <= 70'(t63_r[c]) * 70'(rsde_pkg::RECIP5_LO);
      prh64_r[c] <= 45'(t63_r[c]) * 45'(rsde_pkg::RECIP5_HI);
    end
    t63_r[0]  <= rnd[53:16];
    t63_r[1]  <= rnd_q[53:16];
    j_out_r   <= res_nxt[0];
    q_out_r   <= res_nxt[1];
    ovf_out_r <= sat_nxt[0] | sat_nxt[1];
  end

  assign out_valid    = v_r[LAT-1];
  assign out_j_value  = j_out_r;
  assign out_q_value  = q_out_r;
  assign out_overflow = ovf_out_r;

endmodule

@@ bench/tb_reduced_spectral_density_eval.sv @@
`timescale 1ns / 1ps
// Testbench for the five-term spectral density evaluator: predicts and checks J, Q and overflow.
module tb_reduced_spectral_density_eval;

  // Index 7 is not a register; writes there must be dropped.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int TERMS = 5;
  localparam int DRAIN_CYCLES = 80;   // pipeline is 65 deep
  localparam logic [127:0] ONES64 = {64'b0, {64{1'b1}}};
  localparam logic [63:0] PART_CAP = 64'd1 << 56;
  localparam logic [63:0] TWO_PI_Q32 = {29'd0, rsde_pkg::TWO_PI_HI, rsde_pkg::TWO_PI_LO};
  localparam logic [63:0] FIVE_UNITS = 64'd5 << 16;

  typedef struct {
    logic [31:0] row;
    logic [31:0] col;
  } energy_pair_t;

  typedef struct {
    logic [47:0] j;
    logic [47:0] q;
    logic        ovf;
  } density_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_energy_row = '0;
  logic [31:0] in_energy_col = '0;
  logic        out_valid;
  logic [47:0] out_j_value;
  logic [47:0] out_q_value;
  logic        out_overflow;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [62:0] cfg_data = '0;

  // Shadow copy of the configuration, used by the predictor
  logic [62:0] term_shadow [TERMS];
  logic        hertz_shadow;
  logic [31:0] shift_shadow;

  energy_pair_t pending_pairs[$];
  density_t     expected_density[$];
  int           mismatches = 0;
  bit           took = 1'b0;
  int           gap = 0;
  bit           burst = 1'b0;

  reduced_spectral_density_eval dut (
    .clk, .rst_n, .start, .busy, .in_energy_row, .in_energy_col,
    .out_valid, .out_j_value, .out_q_value, .out_overflow,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  // Wide multiply, shift right, clamp to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> s;
    return (p[127:64] != 0) ? ONES64[63:0] : p[63:0];
  endfunction

  // Divide a signed Q.16 sum by five, round half away from zero, clamp to 48 bits
  function automatic logic [47:0] scale_down(longint sum, inout logic ovf);
    logic [63:0] mag;
    bit neg;
    neg = sum < 0;
    mag = neg ? -sum : sum;
    mag = (mag + FIVE_UNITS / 2) / FIVE_UNITS;
    if (neg) begin
      if (mag > {16'b0, rsde_pkg::OUT_NEG_MAG}) begin
        mag = {16'b0, rsde_pkg::OUT_NEG_MAG};
        ovf = 1'b1;
      end
      mag = -mag;
      return mag[47:0];
    end
    if (mag > {16'b0, rsde_pkg::OUT_POS_MAX}) begin
      mag = {16'b0, rsde_pkg::OUT_POS_MAX};
      ovf = 1'b1;
    end
    return mag[47:0];
  endfunction

  function automatic density_t predict_density(logic [31:0] row, logic [31:0] col);
    density_t d;
    longint w, sj, sq;
    logic [63:0] wmag, om, tau, cmag, x, x2, den, lt, qt, wj, wq;
    logic [31:0] craw;
    bit wneg, cneg;
    w = longint'($signed(row)) - longint'($signed(col)) + longint'($signed(shift_shadow));
    wneg = w < 0;
    wmag = wneg ? -w : w;
    om = hertz_shadow ? mul_shift(wmag, TWO_PI_Q32, 8) : wmag << 24;
    sj = 0;
    sq = 0;
    for (int k = 0; k < TERMS; k++) begin
      tau = {33'b0, term_shadow[k][62:32]};
      craw = term_shadow[k][31:0];
      cneg = craw[31];
      cmag = cneg ? (64'h1_0000_0000 - {32'b0, craw}) : {32'b0, craw};
      x = mul_shift(tau, om, 32);
      x2 = mul_shift(x, x, 48);
      den = (x2 > ONES64[63:0] - 64'h10000) ? ONES64[63:0] : x2 + 64'h10000;
      lt = (tau << 32) / den;
      qt = mul_shift(x, lt, 32);
      wj = mul_shift(lt, cmag, 28);
      wq = mul_shift(qt, cmag, 28);
      if (wj > PART_CAP) wj = PART_CAP;
      if (wq > PART_CAP) wq = PART_CAP;
      sj += cneg ? -longint'(wj) : longint'(wj);
      sq += (cneg != wneg) ? -longint'(wq) : longint'(wq);
    end
    d.ovf = 1'b0;
    d.j = scale_down(sj, d.ovf);
    d.q = scale_down(sq, d.ovf);
    return d;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Monitor: log each accepted request's prediction, check each result against the oldest
  always @(posedge clk) begin
    density_t want;
    took = start && !busy && rst_n;
    if (took) expected_density.push_back(predict_density(in_energy_row, in_energy_col));
    if (rst_n && out_valid) begin
      if (expected_density.size() == 0) begin
        report("unexpected result j", out_j_value, '0);
      end else begin
        want = expected_density.pop_front();
        if (out_j_value !== want.j) report("j_value", out_j_value, want.j);
        if (out_q_value !== want.q) report("q_value", out_q_value, want.q);
        if (out_overflow !== want.ovf) begin
          report("overflow", 48'(out_overflow), 48'(want.ovf));
        end
      end
    end
  end

  // Driver: hold a request until taken, then wait a random gap before the next
  always @(negedge clk) begin
    energy_pair_t p;
    if (rst_n && !(start && !took)) begin
      if (took) begin
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 11);
      end
      if (gap == 0 && pending_pairs.size() != 0) begin
        p = pending_pairs.pop_front();
        in_energy_row <= p.row;
        in_energy_col <= p.col;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if (gap > 0) gap--;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [62:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx < rsde_pkg::REG_HERTZ_MODE) term_shadow[idx] = data;
    else if (idx == rsde_pkg::REG_HERTZ_MODE) hertz_shadow = data[0];
    else if (idx == rsde_pkg::REG_FREQ_SHIFT) shift_shadow = data[31:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [62:0] random_term();
    logic [30:0] tau;
    tau = 31'($urandom() >> $urandom_range(1, 31));
    if ($urandom_range(0, 9) == 0) tau = '0;
    return {tau, 32'($urandom())};
  endfunction

  // Energies: mostly near each other so tau*w lands around one, some full range
  function automatic logic [31:0] random_energy(logic [31:0] base);
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) != 0) v = base + ($signed(v) >>> $urandom_range(0, 31));
    return v;
  endfunction

  task automatic add_pair(logic [31:0] row, logic [31:0] col);
    energy_pair_t p;
    p.row = row;
    p.col = col;
    pending_pairs.push_back(p);
  endtask

  task automatic add_directed();
    add_pair(32'h7FFF_FFFF, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(32'd0, 32'd0);
    add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_pair(32'd1, 32'd0);
    add_pair(32'hFFFF_FFFF, 32'd0);
    add_pair(32'd0, 32'h8000_0000);
    add_pair(32'd1000, 32'd3);
    add_pair(32'hFFFF_FF00, 32'd77);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Wait for every result, then let the pipeline settle before touching registers
  task automatic drain();
    wait (pending_pairs.size() == 0 && !start && expected_density.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] base;
    for (int k = 0; k < TERMS; k++) term_shadow[k] = '0;
    hertz_shadow = 1'b0;
    shift_shadow = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: everything evaluates to zero
    add_directed();
    drain();

    // Extreme terms: longest tau, zero tau, most negative and positive weights
    write_reg(rsde_pkg::REG_TERM0 + 3'd0, {31'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(rsde_pkg::REG_TERM0 + 3'd1, {31'd0, 32'h8000_0000});
    write_reg(rsde_pkg::REG_TERM0 + 3'd2, {31'd1, 32'h8000_0000});
    write_reg(rsde_pkg::REG_TERM0 + 3'd3, {31'd1000, 32'h1000_0000});
    write_reg(rsde_pkg::REG_TERM0 + 3'd4, {31'd65536, 32'hF000_0000});
    write_reg(REG_UNUSED, '1);
    add_directed();
    drain();
    write_reg(rsde_pkg::REG_HERTZ_MODE, 63'd1);
    write_reg(rsde_pkg::REG_FREQ_SHIFT, 63'h8000_0000);
    add_directed();
    drain();
    write_reg(rsde_pkg::REG_FREQ_SHIFT, 63'h7FFF_FFFF);
    add_directed();
    drain();

    // Random phases, each with a fresh configuration
    for (int ph = 0; ph < 7; ph++) begin
      for (int k = 0; k < TERMS; k++) write_reg(rsde_pkg::REG_TERM0 + 3'(k), random_term());
      write_reg(rsde_pkg::REG_HERTZ_MODE, 63'($urandom_range(0, 1)));
      write_reg(rsde_pkg::REG_FREQ_SHIFT, ($urandom_range(0, 1) == 1)
                ? 63'($urandom()) : 63'(32'($signed(32'($urandom())) >>> 16)));
      base = $urandom();
      for (int n = 0; n < 120; n++) add_pair(random_energy(base), random_energy(base));
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
